// ===== rtl/lwet_pkg.sv =====
// Shared types, constants and helper function of the layer window energy trigger.
`default_nettype none

package lwet_pkg;

    // Fixed sizes of the block.
    localparam int unsigned LAYER_LIMIT     = 128;
    localparam int unsigned CUT_TABLE_WORDS = 4;
    localparam int unsigned ENERGY_W        = 20;
    localparam int unsigned SUM_W           = 32;
    localparam int unsigned LAYER_W         = 7;
    localparam int unsigned WINDOW_W        = 8;
    localparam int unsigned COUNT_W         = 5;
    localparam int unsigned SPAN_W          = 9;
    localparam int unsigned LISTED_W        = 3;
    localparam int unsigned CFG_INDEX_W     = 3;
    localparam int unsigned CFG_DATA_W      = 32;
    localparam int unsigned PROD_W          = 24;
    localparam int unsigned IN_DATA_W       = 32;
    localparam int unsigned OUT_DATA_W      = 80;

    // Number of table words that can ever be in use, kept within one to four.
    localparam int unsigned WORDS_MAX =
        (CUT_TABLE_WORDS > 4) ? 4 : ((CUT_TABLE_WORDS < 1) ? 1 : CUT_TABLE_WORDS);

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_CUT_ONE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CUT_TWO     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CUT_THREE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CUT_FOUR    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LISTED_CUTS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BEAM_ENERGY = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_LAYER = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_LAYER  = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [LISTED_W-1:0] LISTED_CUTS_RESET = 3'd1;
    localparam logic [ENERGY_W-1:0] BEAM_ENERGY_RESET = 20'd64000;
    localparam logic [WINDOW_W-1:0] FIRST_LAYER_RESET = 8'd0;
    localparam logic [WINDOW_W-1:0] STOP_LAYER_RESET  = 8'd20;

    typedef struct packed {
        logic [3:0][SUM_W-1:0]  cut_table;
        logic [LISTED_W-1:0]    listed_cuts;
        logic [ENERGY_W-1:0]    beam_energy;
        logic [WINDOW_W-1:0]    first_layer;
        logic [WINDOW_W-1:0]    stop_layer;
    } cfg_t;

    // Number of cut table words in use: the register value clamped to one..WORDS_MAX.
    function automatic logic [LISTED_W-1:0] words_in_use(input logic [LISTED_W-1:0] listed);
        logic [LISTED_W-1:0] n;
        n = listed;
        if (n == '0)
        begin
            n = LISTED_W'(1);
        end
        if (n > LISTED_W'(WORDS_MAX))
        begin
            n = LISTED_W'(WORDS_MAX);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lwet_cfg_regs.sv =====
// Configuration register bank of the layer window energy trigger.
`default_nettype none

module lwet_cfg_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [lwet_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [lwet_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output lwet_pkg::cfg_t                           cfg
);

    lwet_pkg::cfg_t cfg_reg;
    lwet_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                lwet_pkg::REG_CUT_ONE:     cfg_next.cut_table[0] = cfg_wdata;
                lwet_pkg::REG_CUT_TWO:     cfg_next.cut_table[1] = cfg_wdata;
                lwet_pkg::REG_CUT_THREE:   cfg_next.cut_table[2] = cfg_wdata;
                lwet_pkg::REG_CUT_FOUR:    cfg_next.cut_table[3] = cfg_wdata;
                lwet_pkg::REG_LISTED_CUTS:
                    cfg_next.listed_cuts = cfg_wdata[lwet_pkg::LISTED_W-1:0];
                lwet_pkg::REG_BEAM_ENERGY:
                    cfg_next.beam_energy = cfg_wdata[lwet_pkg::ENERGY_W-1:0];
                lwet_pkg::REG_FIRST_LAYER:
                    cfg_next.first_layer = cfg_wdata[lwet_pkg::WINDOW_W-1:0];
                lwet_pkg::REG_STOP_LAYER:
                    cfg_next.stop_layer = cfg_wdata[lwet_pkg::WINDOW_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cut_table   <= '0;
            cfg_reg.listed_cuts <= lwet_pkg::LISTED_CUTS_RESET;
            cfg_reg.beam_energy <= lwet_pkg::BEAM_ENERGY_RESET;
            cfg_reg.first_layer <= lwet_pkg::FIRST_LAYER_RESET;
            cfg_reg.stop_layer  <= lwet_pkg::STOP_LAYER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/layer_window_energy_trigger_core.sv =====
// Top level of the layer window energy trigger: hit accumulation and cut decision.
`default_nettype none

// Layer window energy trigger.
// Input stream (s_axis_*): one transaction per calorimeter hit or end marker. tuser is the
// hit flag, tlast marks the final transaction of an event, and tdata carries the layer,
// the energy in 1/8 MeV units and, on the final transaction, the signed electron count.
// A hit whose layer lies in [first_layer, stop_layer) and below the layer limit is added
// to a saturating 32-bit running sum.
// Output stream (m_axis_*): one transaction per event, carrying the pass flag
// (sum at or below the cut), the sum, the chosen cut, the layer span and the count.
// Throughput is one input transaction per cycle unless a stalled output holds back a final
// transaction; the running sum adder in the first stage feeds back on its own register. A
// result passes the stage 1, stage 2 and output registers after its final transaction is
// accepted: the first stage adds the hit and forms the (count - 1) * beam_energy product,
// the second adds the product to the base cut, saturates and compares. When the receiver
// stalls, the result stays in the output register and the stages behind it keep filling;
// s_axis_tready falls once a final transaction cannot move on. A hit that is not final
// never waits in stage 1 for the output side. Reset clears the running sum, all stage
// valid flags and restores the register defaults. Configuration is written through cfg_we,
// cfg_index and cfg_wdata, by the user only while the block is idle; nothing enforces this.

module layer_window_energy_trigger_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input stream.
    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    // tdata: hit_layer [6:0], hit_energy [26:7], electron_count [31:27].
    input  wire logic [lwet_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: hit_valid.
    input  wire logic                                s_axis_tuser,
    input  wire logic                                s_axis_tlast,
    // Output stream.
    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata: pass [0], energy_sum [32:1], energy_cut [64:33], layer_span [73:65],
    // event_electrons [78:74], zero [79].
    output      logic [lwet_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Configuration write port.
    input  wire logic                                cfg_we,
    input  wire logic [lwet_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [lwet_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int unsigned SUM_W    = lwet_pkg::SUM_W;
    localparam int unsigned ENERGY_W = lwet_pkg::ENERGY_W;
    localparam int unsigned LAYER_W  = lwet_pkg::LAYER_W;
    localparam int unsigned WINDOW_W = lwet_pkg::WINDOW_W;
    localparam int unsigned COUNT_W  = lwet_pkg::COUNT_W;
    localparam int unsigned SPAN_W   = lwet_pkg::SPAN_W;
    localparam int unsigned PROD_W   = lwet_pkg::PROD_W;
    localparam logic [SPAN_W-1:0] LAYER_LIMIT_W = SPAN_W'(lwet_pkg::LAYER_LIMIT);

    lwet_pkg::cfg_t cfg;

    lwet_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Stage 1: the accepted input transaction.
    logic                       s1_valid_reg,  s1_valid_next;
    logic                       s1_hit_reg;
    logic                       s1_last_reg;
    logic [LAYER_W-1:0]         s1_layer_reg;
    logic [ENERGY_W-1:0]        s1_energy_reg;
    logic [COUNT_W-1:0]         s1_count_reg;

    // Running sum of the current event.
    logic [SUM_W-1:0]           acc_reg, acc_next;

    // Stage 2: final sum and cut terms of an event.
    logic                       s2_valid_reg, s2_valid_next;
    logic [SUM_W-1:0]           s2_sum_reg;
    logic [SUM_W-1:0]           s2_base_reg;
    logic [PROD_W-1:0]          s2_prod_reg;
    logic [COUNT_W-1:0]         s2_count_reg;

    // Output register.
    logic                       out_valid_reg, out_valid_next;
    logic [lwet_pkg::OUT_DATA_W-1:0] out_data_reg;

    // Handshake and stage movement.
    logic in_accept;
    logic s1_adv;
    logic s2_adv;
    logic s2_free;
    logic out_free;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s2_adv        = s2_valid_reg && out_free;
    assign s2_free       = !s2_valid_reg || s2_adv;
    assign s1_adv        = s1_valid_reg && (!s1_last_reg || s2_free);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Stage 1 logic: window check and saturating accumulation.
    logic                 in_window;
    logic [SUM_W:0]       acc_wide;
    logic [SUM_W-1:0]     acc_added;

    always_comb
    begin
        in_window = s1_hit_reg
            && ({1'b0, s1_layer_reg} >= cfg.first_layer)
            && ({1'b0, s1_layer_reg} < cfg.stop_layer)
            && ({2'b00, s1_layer_reg} < LAYER_LIMIT_W);
        acc_wide  = {1'b0, acc_reg} + (SUM_W + 1)'(s1_energy_reg);
        if (!in_window)
        begin
            acc_added = acc_reg;
        end
        else if (acc_wide[SUM_W])
        begin
            acc_added = '1;
        end
        else
        begin
            acc_added = acc_wide[SUM_W-1:0];
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (s1_adv)
        begin
            acc_next = s1_last_reg ? '0 : acc_added;
        end
    end

    // Stage 1 logic: cut terms from the electron count.
    // A count of zero or below gives a zero cut, a count within the table picks a word,
    // and a larger count extends the first word by beam_energy per extra electron.
    logic                       count_pos;
    logic [COUNT_W-2:0]         count_mag;
    logic [COUNT_W-2:0]         count_less;
    logic [lwet_pkg::LISTED_W-1:0] words;
    logic                       in_table;
    logic [SUM_W-1:0]           base_next;
    logic [PROD_W-1:0]          prod_next;

    always_comb
    begin
        count_pos  = !s1_count_reg[COUNT_W-1] && (s1_count_reg != '0);
        count_mag  = s1_count_reg[COUNT_W-2:0];
        count_less = count_mag - (COUNT_W-1)'(1);
        words      = lwet_pkg::words_in_use(cfg.listed_cuts);
        in_table   = count_mag <= (COUNT_W-1)'(words);
        base_next  = '0;
        prod_next  = '0;
        if (count_pos)
        begin
            if (in_table)
            begin
                base_next = cfg.cut_table[count_less[1:0]];
            end
            else
            begin
                base_next = cfg.cut_table[0];
                prod_next = PROD_W'(count_less) * PROD_W'(cfg.beam_energy);
            end
        end
    end

    // Stage 2 logic: saturated cut, decision and packing.
    logic [SUM_W:0]       cut_wide;
    logic [SUM_W-1:0]     cut_sat;
    logic [SPAN_W-1:0]    span;
    logic                 pass_bit;

    always_comb
    begin
        cut_wide = {1'b0, s2_base_reg} + (SUM_W + 1)'(s2_prod_reg);
        cut_sat  = cut_wide[SUM_W] ? '1 : cut_wide[SUM_W-1:0];
        span     = {1'b0, cfg.stop_layer} - {1'b0, cfg.first_layer};
        pass_bit = s2_sum_reg <= cut_sat;
    end

    // Valid flags.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s1_adv && s1_last_reg)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s2_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_hit_reg    <= s_axis_tuser;
            s1_last_reg   <= s_axis_tlast;
            s1_layer_reg  <= s_axis_tdata[LAYER_W-1:0];
            s1_energy_reg <= s_axis_tdata[LAYER_W+ENERGY_W-1:LAYER_W];
            s1_count_reg  <= s_axis_tdata[LAYER_W+ENERGY_W+COUNT_W-1:LAYER_W+ENERGY_W];
        end
        if (s1_adv && s1_last_reg)
        begin
            s2_sum_reg   <= acc_added;
            s2_base_reg  <= base_next;
            s2_prod_reg  <= prod_next;
            s2_count_reg <= s1_count_reg;
        end
        if (s2_adv)
        begin
            out_data_reg <= {1'b0, s2_count_reg, span, cut_sat, s2_sum_reg, pass_bit};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTH
    // The running sum starts over right after the final transaction of an event.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_last_reg) |=> (acc_reg == '0))
        else $error("running sum not cleared after event end");

    // Within an event the saturating sum never goes down.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_adv && s1_last_reg) |=> (acc_reg >= $past(acc_reg)))
        else $error("running sum decreased within an event");

    // The pass flag agrees with the sum and cut that travel with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg[0] == (out_data_reg[32:1] <= out_data_reg[64:33])))
        else $error("pass flag inconsistent with sum and cut");

    // A count of zero or a negative count yields a zero cut.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg[78] || (out_data_reg[78:74] == '0)))
            |-> (out_data_reg[64:33] == '0))
        else $error("nonzero cut for an event without electrons");
`endif

endmodule

`default_nettype wire
